[hw/rtl/kdtt_pkg.sv]
package kdtt_pkg;

  // request codes as they arrive in tuser
  localparam logic [2:0] REQ_ADD_ALL = 3'd0;
  localparam logic [2:0] REQ_ADD_ONE = 3'd1;
  localparam logic [2:0] REQ_BARRIER = 3'd2;
  localparam logic [2:0] REQ_QUERY   = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  localparam int REQ_W     = 3;
  localparam int DIDX_W    = 4;   // disk_index field
  localparam int TABLET_W  = 64;
  localparam int CHAN_W    = 8;
  localparam int HALF_W    = 32;  // generation / step
  localparam int PAIR_W    = 64;
  localparam int SYNC_W    = 16;
  localparam int SUBG_W    = 5;
  localparam int DSEL_W    = 5;   // enough for the largest disk count
  localparam int KEY_W     = TABLET_W + CHAN_W;
  localparam int IN_DATA_W = 160;
  localparam int OUT_DATA_W = 8;
  localparam logic [SUBG_W-1:0] SUBG_RESET = 5'd8;

  // classified operation
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD_ALL,
    OP_ADD_ONE,
    OP_BARRIER,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  // item handed from the front to the engine
  typedef struct packed {
    op_t                 op;
    logic [DSEL_W-1:0]   d_first;
    logic [DSEL_W-1:0]   d_last;
    logic [TABLET_W-1:0] tablet;
    logic [CHAN_W-1:0]   channel;
    logic [PAIR_W-1:0]   gs;
    logic [SYNC_W-1:0]   synced;
  } item_t;

endpackage

[hw/rtl/keyed_disk_threshold_table.sv]
// Sequence: a lookup reads and checks the entries one after another until the key
// matches, then reads and checks each disk touched in the threshold memory, and ends
// with queueing, write-back and output; clear sweeps the whole entry memory.
// Throughput: one item at a time through the engine, bound by the key scan through one read port;
// a 2-item input queue and an output register let both sides stall on their own.
// Reset (rst_n low, synchronous): sweep of every entry of the entry memory, no items taken.
module keyed_disk_threshold_table #(
  parameter int ENTRIES = 64,
  parameter int DISKS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // disk_index[3:0], tablet_id[67:4], channel[75:68], generation[107:76],
  // step[139:108], synced_mask[155:140], zero fill
  input  logic [kdtt_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[2:0]
  input  logic [kdtt_pkg::REQ_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // behind[0], table_full[1], zero fill
  output logic [kdtt_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kdtt_pkg::SUBG_W-1:0]      cfg_data
);
  import kdtt_pkg::*;

  item_t item;
  logic  item_valid, item_pop, sweep_busy;

  kdtt_front #(.DISKS(DISKS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .sweep_busy(sweep_busy),
    .item_valid(item_valid), .item(item), .item_pop(item_pop));

  kdtt_engine #(.ENTRIES(ENTRIES), .DISKS(DISKS)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(item_valid), .item(item), .item_pop(item_pop),
    .sweep_busy(sweep_busy),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));

  // no item enters while the entry memory is being swept
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_busy |-> !in_tready) else $error("item accepted during sweep");

  // a result never reports both behind and a dropped add
  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1])) else $error("behind and full both set");

  // reset starts the sweep with the output empty
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> (sweep_busy && !out_tvalid)) else $error("reset did not start sweep");

  // the engine only takes an item that the queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> item_valid) else $error("pop from empty queue");
endmodule

[hw/rtl/kdtt_ram.sv]
module kdtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/kdtt_front.sv]
module kdtt_front #(
  parameter int DISKS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kdtt_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [kdtt_pkg::REQ_W-1:0]       in_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kdtt_pkg::SUBG_W-1:0]      cfg_data,
  input  logic                             sweep_busy,
  output logic                             item_valid,
  output kdtt_pkg::item_t                  item,
  input  logic                             item_pop
);
  import kdtt_pkg::*;

  logic [SUBG_W-1:0] subg_r;
  item_t             cls;
  item_t             q_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push;
  int                nact;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (cnt_r != 2'd2) && !sweep_busy;
  assign push       = in_tvalid && in_tready;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];

  // classify the incoming item
  always_comb begin
    nact = (int'(subg_r) > DISKS) ? DISKS : int'(subg_r);
    cls.tablet  = in_tdata[67:4];
    cls.channel = in_tdata[75:68];
    cls.gs      = {in_tdata[107:76], in_tdata[139:108]};
    cls.synced  = in_tdata[155:140];
    cls.d_first = DSEL_W'(in_tdata[3:0]);
    cls.d_last  = DSEL_W'(in_tdata[3:0]);
    cls.op      = OP_NOP;
    unique case (in_tuser)
      REQ_ADD_ALL, REQ_QUERY: begin
        cls.d_first = '0;
        cls.d_last  = DSEL_W'(nact - 1);
        if (nact != 0) begin
          cls.op = (in_tuser == REQ_QUERY) ? OP_QUERY : OP_ADD_ALL;
        end
      end
      REQ_ADD_ONE: begin
        if (int'(in_tdata[3:0]) < DISKS) cls.op = OP_ADD_ONE;
      end
      REQ_BARRIER: begin
        if (int'(in_tdata[3:0]) < DISKS) cls.op = OP_BARRIER;
      end
      REQ_CLEAR: cls.op = OP_CLEAR;
      default:   cls.op = OP_NOP;
    endcase
  end

  // config register and two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subg_r <= SUBG_RESET;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (cfg_valid) subg_r <= cfg_data;
      if (push) wp_r <= !wp_r;
      if (item_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(item_pop);
    end
    if (push) q_r[wp_r] <= cls;
  end
endmodule

[hw/rtl/kdtt_engine.sv]
module kdtt_engine #(
  parameter int ENTRIES = 64,
  parameter int DISKS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_valid,
  input  kdtt_pkg::item_t                  item,
  output logic                             item_pop,
  output logic                             sweep_busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kdtt_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import kdtt_pkg::*;

  localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW     = (DISKS > 1) ? $clog2(DISKS) : 1;
  localparam int TDEPTH = ENTRIES << DW;
  localparam int META_W = DISKS + 1;
  localparam logic [EW-1:0] LAST_E = EW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_KRD, S_KCHK, S_DRD, S_DCHK, S_FIN, S_RES
  } state_t;

  state_t            st_r, st_nxt;
  item_t             it_r, it_nxt;
  logic [EW-1:0]     idx_r, idx_nxt, e_r, e_nxt, free_i_r, free_i_nxt;
  logic              free_f_r, free_f_nxt, new_r, new_nxt, sres_r, sres_nxt;
  logic [DW-1:0]     d_r, d_nxt;
  logic [DISKS-1:0]  pres_r, pres_nxt, sync_ext;
  logic              behind_r, behind_nxt, full_r, full_nxt, ov_r, ov_nxt;
  logic [1:0]        od_r, od_nxt;

  logic              meta_we, key_we, thr_we;
  logic [EW-1:0]     meta_wa;
  logic [META_W-1:0] meta_wd, meta_q;
  logic [KEY_W-1:0]  key_q;
  logic [PAIR_W-1:0] thr_q;
  logic              hit, p, is_add, fnd;
  logic [EW-1:0]     fidx;

  kdtt_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
    .raddr(idx_r), .rdata(meta_q));

  kdtt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key (
    .clk(clk), .we(key_we), .waddr(e_r), .wdata({it_r.tablet, it_r.channel}),
    .raddr(idx_r), .rdata(key_q));

  kdtt_ram #(.WIDTH(PAIR_W), .DEPTH(TDEPTH)) u_thr (
    .clk(clk), .we(thr_we), .waddr({e_r, d_r}), .wdata(it_r.gs),
    .raddr({e_r, d_r}), .rdata(thr_q));

  assign sweep_busy = (st_r == S_SWEEP);
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, od_r};

  // disks above the mask width count as unsynced
  always_comb begin
    for (int i = 0; i < DISKS; i++) begin
      sync_ext[i] = (i < SYNC_W) ? it_r.synced[i % SYNC_W] : 1'b0;
    end
  end

  assign hit    = meta_q[DISKS] && (key_q == {it_r.tablet, it_r.channel});
  assign p      = pres_r[d_r];
  assign is_add = (it_r.op == OP_ADD_ALL) || (it_r.op == OP_ADD_ONE);
  assign fnd    = free_f_r || !meta_q[DISKS];
  assign fidx   = free_f_r ? free_i_r : idx_r;

  // sequencer: key scan, per-disk read-modify-write, result
  always_comb begin
    st_nxt = st_r;  it_nxt = it_r;  idx_nxt = idx_r;  e_nxt = e_r;
    free_i_nxt = free_i_r;  free_f_nxt = free_f_r;  new_nxt = new_r;
    sres_nxt = sres_r;  d_nxt = d_r;  pres_nxt = pres_r;
    behind_nxt = behind_r;  full_nxt = full_r;  ov_nxt = ov_r;  od_nxt = od_r;
    item_pop = 1'b0;  meta_we = 1'b0;  key_we = 1'b0;  thr_we = 1'b0;
    meta_wa = e_r;  meta_wd = '0;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    unique case (st_r)
      S_SWEEP: begin
        meta_we = 1'b1;
        meta_wa = idx_r;
        if (idx_r == LAST_E) begin
          st_nxt = sres_r ? S_RES : S_IDLE;
        end else begin
          idx_nxt = idx_r + EW'(1);
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          item_pop   = 1'b1;
          it_nxt     = item;
          idx_nxt    = '0;
          free_f_nxt = 1'b0;
          behind_nxt = 1'b0;
          full_nxt   = 1'b0;
          new_nxt    = 1'b0;
          unique case (item.op)
            OP_NOP:   st_nxt = S_RES;
            OP_CLEAR: begin
              st_nxt   = S_SWEEP;
              sres_nxt = 1'b1;
            end
            default:  st_nxt = S_KRD;
          endcase
        end
      end
      S_KRD: st_nxt = S_KCHK;
      S_KCHK: begin
        d_nxt = it_r.d_first[DW-1:0];
        if (hit) begin
          e_nxt    = idx_r;
          pres_nxt = meta_q[DISKS-1:0];
          st_nxt   = S_DRD;
        end else begin
          if (!free_f_r && !meta_q[DISKS]) begin
            free_f_nxt = 1'b1;
            free_i_nxt = idx_r;
          end
          if (idx_r != LAST_E) begin
            idx_nxt = idx_r + EW'(1);
            st_nxt  = S_KRD;
          end else if (is_add && fnd) begin
            e_nxt    = fidx;
            pres_nxt = '0;
            new_nxt  = 1'b1;
            st_nxt   = S_DRD;
          end else begin
            full_nxt = is_add;
            st_nxt   = S_RES;
          end
        end
      end
      S_DRD: st_nxt = S_DCHK;
      S_DCHK: begin
        priority if (is_add) begin
          thr_we       = !p || (thr_q < it_r.gs);
          pres_nxt[d_r] = 1'b1;
          if (d_r == it_r.d_last[DW-1:0]) begin
            st_nxt = S_FIN;
          end else begin
            d_nxt  = d_r + DW'(1);
            st_nxt = S_DRD;
          end
        end else if (it_r.op == OP_BARRIER) begin
          if (p && (thr_q <= it_r.gs)) pres_nxt[d_r] = 1'b0;
          st_nxt = S_FIN;
        end else begin
          if (!sync_ext[d_r] && p && (thr_q >= it_r.gs)) begin
            behind_nxt = 1'b1;
            st_nxt     = S_RES;
          end else if (d_r == it_r.d_last[DW-1:0]) begin
            st_nxt = S_RES;
          end else begin
            d_nxt  = d_r + DW'(1);
            st_nxt = S_DRD;
          end
        end
      end
      S_FIN: begin
        // barrier frees the entry when no threshold is left
        meta_we = 1'b1;
        meta_wd = {(is_add || (pres_r != '0)), pres_r};
        key_we  = new_r;
        st_nxt  = S_RES;
      end
      S_RES: begin
        if (!ov_r || out_tready) begin
          ov_nxt   = 1'b1;
          od_nxt   = {full_r, behind_r};
          sres_nxt = 1'b0;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_SWEEP;
      idx_r    <= '0;
      sres_r   <= 1'b0;
      ov_r     <= 1'b0;
      free_f_r <= 1'b0;
      new_r    <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      idx_r    <= idx_nxt;
      sres_r   <= sres_nxt;
      ov_r     <= ov_nxt;
      free_f_r <= free_f_nxt;
      new_r    <= new_nxt;
    end
    it_r     <= it_nxt;
    e_r      <= e_nxt;
    free_i_r <= free_i_nxt;
    d_r      <= d_nxt;
    pres_r   <= pres_nxt;
    behind_r <= behind_nxt;
    full_r   <= full_nxt;
    od_r     <= od_nxt;
  end
endmodule

[bench/keyed_disk_threshold_table_checker.sv]
module keyed_disk_threshold_table_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [kdtt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [kdtt_pkg::REQ_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [kdtt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [kdtt_pkg::SUBG_W-1:0]     cfg_data,
  output int                              fail_count,
  output int                              pending_answers
);
  timeunit 1ns;
  timeprecision 1ps;
  import kdtt_pkg::*;

  localparam int NENT  = 64;
  localparam int NDISK = 16;

  typedef struct packed {
    logic table_full;
    logic behind;
  } answer_t;

  // shadow copy of the table
  logic [SUBG_W-1:0] subgroup;
  logic              live [NENT];
  logic [63:0]       tab_key [NENT];
  logic [7:0]        chan_key [NENT];
  logic [15:0]       present [NENT];
  logic [63:0]       thresh [NENT][NDISK];
  answer_t           answer_q [$];

  function automatic int lookup(logic [63:0] tab, logic [7:0] ch);
    for (int i = 0; i < NENT; i++)
      if (live[i] && tab_key[i] == tab && chan_key[i] == ch) return i;
    return -1;
  endfunction

  function automatic int claim(logic [63:0] tab, logic [7:0] ch);
    int e;
    e = lookup(tab, ch);
    if (e >= 0) return e;
    for (int i = 0; i < NENT; i++)
      if (!live[i]) begin
        live[i] = 1'b1;
        tab_key[i] = tab;
        chan_key[i] = ch;
        present[i] = '0;
        return i;
      end
    return -1;
  endfunction

  function automatic void raise(int e, int d, logic [63:0] gs);
    if (!present[e][d]) begin
      present[e][d] = 1'b1;
      thresh[e][d] = gs;
    end else if (thresh[e][d] < gs) begin
      thresh[e][d] = gs;
    end
  endfunction

  // apply one request and return its answer
  function automatic answer_t apply_request(logic [2:0] req, logic [IN_DATA_W-1:0] data);
    logic [3:0]  disk;
    logic [63:0] tab;
    logic [7:0]  ch;
    logic [63:0] gs;
    logic [15:0] synced;
    int          n;
    int          e;
    answer_t     a;
    disk   = data[3:0];
    tab    = data[67:4];
    ch     = data[75:68];
    gs     = {data[107:76], data[139:108]};
    synced = data[155:140];
    n = (subgroup > NDISK) ? NDISK : int'(subgroup);
    a = '0;
    case (req)
      REQ_ADD_ALL: begin
        if (n != 0) begin
          e = claim(tab, ch);
          if (e < 0) a.table_full = 1'b1;
          else for (int d = 0; d < n; d++) raise(e, d, gs);
        end
      end
      REQ_ADD_ONE: begin
        e = claim(tab, ch);
        if (e < 0) a.table_full = 1'b1;
        else raise(e, int'(disk), gs);
      end
      REQ_BARRIER: begin
        e = lookup(tab, ch);
        if (e >= 0) begin
          if (present[e][disk] && thresh[e][disk] <= gs) present[e][disk] = 1'b0;
          if (present[e] == '0) live[e] = 1'b0;
        end
      end
      REQ_QUERY: begin
        e = lookup(tab, ch);
        if (e >= 0)
          for (int d = 0; d < n; d++)
            if (!synced[d] && present[e][d] && thresh[e][d] >= gs) a.behind = 1'b1;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < NENT; i++) begin
          live[i] = 1'b0;
          present[i] = '0;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  assign pending_answers = answer_q.size();

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      subgroup <= SUBG_RESET;
      for (int i = 0; i < NENT; i++) begin
        live[i] = 1'b0;
        present[i] = '0;
      end
      answer_q = {};
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) subgroup <= cfg_data;
      if (in_tvalid && in_tready) answer_q.push_back(apply_request(in_tuser, in_tdata));
      // compare each result with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = answer_q.pop_front();
          if (out_tdata[0] !== want.behind || out_tdata[1] !== want.table_full
              || out_tdata[7:2] !== '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result differs: behind %b/%b full %b/%b (expected/actual)",
                       want.behind, out_tdata[0], want.table_full, out_tdata[1]);
          end
        end
      end
    end
  end
endmodule

[bench/keyed_disk_threshold_table_test.sv]
module keyed_disk_threshold_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kdtt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic [REQ_W-1:0]        in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [SUBG_W-1:0]       cfg_data;
  int                      fail_count;
  int                      pending_answers;
  int                      cycle_count;
  int                      hold_cycles;

  // small key pool so entries are reused, barriers hit and queries find thresholds
  logic [63:0] tablet_pool [8];

  keyed_disk_threshold_table DUT (.*);

  keyed_disk_threshold_table_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("keyed_disk_threshold_table: mismatch");
        $finish;
      end
    end
  end

  // receiver stall pattern, with long hold-offs when requested
  initial begin
    out_tready = 1'b0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (cycle_count % 1500 < 400) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // drive at the falling edge; back-to-back calls simply keep valid high
  task automatic send_item(logic [2:0] req, logic [3:0] disk, logic [63:0] tab,
                           logic [7:0] ch, logic [31:0] gen, logic [31:0] stp,
                           logic [15:0] synced);
    in_tuser  = req;
    in_tdata  = {4'b0, synced, stp, gen, ch, tab, disk};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending_answers != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_subgroup(logic [4:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [2:0] req;
    int         gap;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    for (int i = 0; i < 8; i++) tablet_pool[i] = {$urandom, $urandom};
    tablet_pool[0] = '0;
    tablet_pool[1] = '1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every request, absent keys, unused codes
    send_item(REQ_QUERY, 4'd0, 64'd5, 8'd1, 0, 0, 16'd0);
    send_item(REQ_BARRIER, 4'd3, 64'd5, 8'd1, 0, 0, 16'd0);
    send_item(REQ_ADD_ALL, 4'd0, '1, 8'hFF, '1, '1, 16'd0);
    send_item(REQ_QUERY, 4'd0, '1, 8'hFF, '1, '1, 16'h0000);
    send_item(REQ_QUERY, 4'd0, '1, 8'hFF, '1, '1, 16'hFFFF);
    send_item(REQ_ADD_ONE, 4'd15, '0, 8'h00, 0, 0, 16'd0);
    send_item(REQ_ADD_ONE, 4'd15, '0, 8'h00, 0, 32'd7, 16'd0);
    send_item(REQ_BARRIER, 4'd15, '0, 8'h00, 0, 32'd6, 16'd0);
    send_item(REQ_BARRIER, 4'd2, '0, 8'h00, '1, '1, 16'd0);
    send_item(REQ_BARRIER, 4'd15, '0, 8'h00, 0, 32'd7, 16'd0);
    send_item(REQ_QUERY, 4'd0, '0, 8'h00, 0, 0, 16'd0);
    send_item(3'd5, 4'hA, 64'h1, 8'h2, 1, 1, 16'h5555);
    send_item(3'd6, 4'h5, 64'h1, 8'h2, 1, 1, 16'hAAAA);
    send_item(3'd7, 4'hF, 64'h1, 8'h2, 1, 1, 16'hFFFF);
    send_item(REQ_CLEAR, 4'd0, 64'd0, 8'd0, 0, 0, 16'd0);
    send_item(REQ_QUERY, 4'd0, '1, 8'hFF, 0, 0, 16'd0);
    // fill the table past its capacity, then clear
    for (int i = 0; i < 66; i++)
      send_item(REQ_ADD_ONE, 4'(i), 64'(i), 8'h3C, i, 0, 16'd0);
    send_item(REQ_ADD_ALL, 4'd0, 64'd999, 8'h0, 1, 1, 16'd0);
    send_item(REQ_CLEAR, 4'd0, 64'd0, 8'd0, 0, 0, 16'd0);

    write_subgroup(5'd0);
    send_item(REQ_ADD_ALL, 4'd0, 64'd7, 8'd7, 3, 3, 16'd0);
    send_item(REQ_QUERY, 4'd0, 64'd7, 8'd7, 0, 0, 16'd0);
    send_item(REQ_ADD_ONE, 4'd2, 64'd7, 8'd7, 3, 3, 16'd0);
    send_item(REQ_QUERY, 4'd0, 64'd7, 8'd7, 0, 0, 16'd0);

    // random phases under several subgroup sizes
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_subgroup(5'd16);
        1: write_subgroup(5'd31);
        2: write_subgroup(5'd1);
        3: write_subgroup(5'($urandom_range(2, 15)));
        default: write_subgroup(5'd17);
      endcase
      for (int k = 0; k < 132; k++) begin
        if (k == 40) hold_cycles = 600;
        if (k == 100) drain();
        if ($urandom_range(0, 4) == 0) begin
          gap = $urandom_range(1, 12);
          repeat (gap) @(negedge clk);
        end
        case ($urandom_range(0, 99)) inside
          [0:24]:  req = REQ_ADD_ALL;
          [25:49]: req = REQ_ADD_ONE;
          [50:69]: req = REQ_BARRIER;
          [70:94]: req = REQ_QUERY;
          [95:97]: req = REQ_CLEAR;
          default: req = 3'($urandom_range(5, 7));
        endcase
        send_item(req, 4'($urandom), ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                  : tablet_pool[$urandom_range(0, 7)],
                  ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3),
                  16'($urandom));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("keyed_disk_threshold_table: match");
    end else begin
      $display("keyed_disk_threshold_table: mismatch");
    end
    $finish;
  end
endmodule
